/* hw/rtl/idcm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// idcm_pkg: shared types and constants
// Constants, kind codes and color modes for the inverse distance color map.
// ----------------------------------------------------------------------------
package idcm_pkg;
    localparam int MaxPoints   = 128;
    localparam int AddrW       = $clog2(MaxPoints);
    localparam int CountW      = $clog2(MaxPoints + 1);
    localparam int WeightShift = 37;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [1:0] MODE_BLACK = 2'd0;
    localparam logic [1:0] MODE_RB    = 2'd1;
    localparam logic [1:0] MODE_RGB   = 2'd2;
    localparam logic [1:0] MODE_GRAY  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] interp_value;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               store_empty;
    } out_item_t;

    // unsigned divider request and reply
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/idcm_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// idcm_in_if / idcm_out_if: valid-ready channels
// One beat moves one item when valid and ready are both high.
// ----------------------------------------------------------------------------
interface idcm_in_if;
    logic               valid;
    logic               ready;
    idcm_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface idcm_out_if;
    logic                valid;
    logic                ready;
    idcm_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/idcm_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// idcm_div: radix-2 restoring divider
// Unsigned 64 by 64 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module idcm_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire idcm_pkg::div_req_t req,
    output idcm_pkg::div_rsp_t     rsp
);
    import idcm_pkg::*;

    logic [63:0] rem_reg, quo_reg, den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] trial;
    logic [64:0] shifted;

    assign shifted = {rem_reg, quo_reg[63]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule
`default_nettype wire

/* hw/rtl/idcm_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// idcm_store: sample point memory
// One write port, one registered read port; x, y and value side by side.
// ----------------------------------------------------------------------------
module idcm_store (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [idcm_pkg::AddrW-1:0]   wr_addr,
    input  wire logic [47:0]                  wr_data,
    input  wire logic [idcm_pkg::AddrW-1:0]   rd_addr,
    output logic [47:0]                       rd_data
);
    import idcm_pkg::*;

    logic [47:0] mem [MaxPoints];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/inverse_distance_color_map.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_distance_color_map: Shepard interpolation with color mapping
// Per query: a walk over the N stored points, a mean divide, then C color
// divides (gray one, red-blue two, red-green-blue three; black none).
// Each point costs a read, a distance, a square and a weight divide;
// an exact hit ends the walk early. One query at a time; clear and load are
// handled in idle. The result register frees the input while a result waits.
// Reset empties the store and sets mode_reg to black; memory is not cleared.
// ----------------------------------------------------------------------------
module inverse_distance_color_map (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    idcm_in_if.sink         in_ch,
    idcm_out_if.source      out_ch
);
    import idcm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_READ, ST_DIST, ST_SQ, ST_WDIV, ST_ACC, ST_QGO,
        ST_QDIV, ST_OUT, ST_COL, ST_CDIV, ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [1:0]          mode_reg;
    logic [CountW-1:0]   count_reg;
    logic [CountW-1:0]   idx_reg;
    logic signed [15:0]  low_reg, high_reg;
    logic signed [15:0]  qx_reg, qy_reg;
    logic [16:0]         ax_reg, ay_reg;
    logic [33:0]         d2_reg;
    logic signed [15:0]  sval_reg;
    logic [63:0]         num_reg, den_reg;
    logic [63:0]         w_reg;
    logic signed [15:0]  q_reg;
    logic [1:0]          comp_reg;
    logic [7:0]          r_reg, g_reg, b_reg;
    logic                empty_reg;
    logic signed [17:0]  d_reg, n_reg;
    logic [63:0]         cnum_reg;
    logic                ovalid_reg;
    out_item_t           odata_reg;
    logic                done_hit_reg;

    logic                wr_en;
    logic [47:0]         rd_data;
    div_req_t            dreq;
    div_rsp_t            drsp;
    logic                slot_free;

    // memory: write on accepted load when not full
    assign wr_en = in_ch.valid && in_ch.ready && in_ch.data.kind == KIND_LOAD
                   && count_reg < CountW'(MaxPoints);

    idcm_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AddrW-1:0]),
        .wr_data ({in_ch.data.pos_x, in_ch.data.pos_y, in_ch.data.sample_value}),
        .rd_addr (idx_reg[AddrW-1:0]),
        .rd_data (rd_data)
    );

    idcm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // the result register takes a new beat once the old one is gone or leaving
    assign slot_free    = !ovalid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    // color numerator for the current component; a zero numerator still goes through the divide
    logic signed [17:0] an;
    logic [63:0]        cnum;
    logic [7:0]         cq;
    assign an = n_reg < 0 ? -n_reg : n_reg;
    always_comb
    begin
        cnum = '0;
        case (mode_reg)
            MODE_RB:
                cnum = comp_reg == 2'd0 ? 64'(127 * (d_reg - n_reg))
                                        : 64'(127 * (d_reg + n_reg));
            MODE_RGB:
                case (comp_reg)
                    2'd0:    cnum = n_reg < 0 ? 64'(255 * an) : 64'd0;
                    2'd1:    cnum = 64'(255 * (d_reg - an));
                    default: cnum = n_reg > 0 ? 64'(255 * an) : 64'd0;
                endcase
            MODE_GRAY: cnum = 64'(127 * (d_reg + n_reg));
            default:   cnum = '0;
        endcase
    end
    assign cq = drsp.quo > 64'd255 ? 8'd255 : drsp.quo[7:0];

    // color setup from q
    logic signed [17:0] dd, nn;
    always_comb
    begin
        dd = 18'(high_reg) - 18'(low_reg);
        if (dd <= 0)
        begin
            dd = 18'sd1;
            nn = '0;
        end
        else
        begin
            nn = 18'sd2 * (18'(q_reg) - 18'(low_reg)) - dd;
            if (nn > dd)  nn = dd;
            if (nn < -dd) nn = -dd;
        end
    end

    logic signed [16:0] dx, dy;
    assign dx = 17'(qx_reg) - 17'(signed'(rd_data[47:32]));
    assign dy = 17'(qy_reg) - 17'(signed'(rd_data[31:16]));

    always_comb
    begin
        dreq = '0;
        if (state_reg == ST_SQ)
        begin
            dreq.start = (34'(ax_reg * ax_reg) + 34'(ay_reg * ay_reg)) != 34'd0;
            dreq.num   = 64'd1 << WeightShift;
            dreq.den   = 64'(34'(ax_reg * ax_reg) + 34'(ay_reg * ay_reg));
        end
        else if (state_reg == ST_QGO)
        begin
            dreq.start = 1'b1;
            dreq.num   = num_reg;
            dreq.den   = den_reg;
        end
        else if (state_reg == ST_COL)
        begin
            dreq.start = 1'b1;
            dreq.num   = cnum;
            dreq.den   = 64'(d_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_BLACK;
            count_reg    <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            ovalid_reg   <= 1'b0;
            idx_reg      <= '0;
            done_hit_reg <= 1'b0;
            comp_reg     <= '0;
            empty_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (state_reg == ST_EMIT && slot_free)
                ovalid_reg <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_ch.valid && in_ch.ready)
                    begin
                        qx_reg <= in_ch.data.pos_x;
                        qy_reg <= in_ch.data.pos_y;
                        idx_reg <= '0;
                        num_reg <= '0;
                        den_reg <= '0;
                        done_hit_reg <= 1'b0;
                        case (in_ch.data.kind)
                            KIND_CLEAR:
                            begin
                                count_reg <= '0;
                                low_reg   <= '0;
                                high_reg  <= '0;
                            end
                            KIND_LOAD:
                                if (wr_en)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                    if (count_reg == '0 ||
                                        in_ch.data.sample_value < low_reg)
                                        low_reg <= in_ch.data.sample_value;
                                    if (count_reg == '0 ||
                                        in_ch.data.sample_value > high_reg)
                                        high_reg <= in_ch.data.sample_value;
                                end
                            KIND_QUERY:
                                if (count_reg == '0)
                                begin
                                    // empty store: zero result, flag set
                                    q_reg     <= '0;
                                    r_reg     <= '0;
                                    g_reg     <= '0;
                                    b_reg     <= '0;
                                    empty_reg <= 1'b1;
                                    state_reg <= ST_EMIT;
                                end
                                else
                                    state_reg <= ST_READ;
                            default: ;
                        endcase
                    end
                ST_READ: state_reg <= ST_DIST;
                ST_DIST:
                begin
                    ax_reg   <= dx < 0 ? 17'(-dx) : 17'(dx);
                    ay_reg   <= dy < 0 ? 17'(-dy) : 17'(dy);
                    sval_reg <= signed'(rd_data[15:0]);
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                    if (dreq.start)
                        state_reg <= ST_WDIV;
                    else
                    begin
                        // exact hit: take this sample's value
                        q_reg        <= sval_reg;
                        done_hit_reg <= 1'b1;
                        state_reg    <= ST_QDIV;
                    end
                ST_WDIV:
                    if (drsp.done)
                    begin
                        w_reg     <= drsp.quo;
                        state_reg <= ST_ACC;
                    end
                ST_ACC:
                begin
                    num_reg <= num_reg + 64'(w_reg[37:0] *
                               {1'b0, ~sval_reg[15], sval_reg[14:0]});
                    den_reg <= den_reg + w_reg;
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= (idx_reg + 1'b1 == count_reg) ? ST_QGO : ST_READ;
                end
                // launch the final divide for one cycle
                ST_QGO: state_reg <= ST_QDIV;
                ST_QDIV:
                    if (done_hit_reg)
                        state_reg <= ST_OUT;
                    else if (drsp.done)
                    begin
                        q_reg     <= signed'(drsp.quo[15:0] ^ 16'h8000);
                        state_reg <= ST_OUT;
                    end
                ST_OUT:
                begin
                    d_reg     <= dd;
                    n_reg     <= nn;
                    comp_reg  <= '0;
                    empty_reg <= 1'b0;
                    r_reg <= '0; g_reg <= '0; b_reg <= '0;
                    state_reg <= mode_reg == MODE_BLACK ? ST_CDIV : ST_COL;
                end
                ST_COL: state_reg <= ST_CDIV;
                ST_CDIV:
                    if (mode_reg == MODE_BLACK || drsp.done)
                    begin
                        if (mode_reg == MODE_GRAY)
                        begin
                            r_reg <= cq;
                            g_reg <= cq;
                            b_reg <= cq;
                        end
                        else if (mode_reg != MODE_BLACK)
                            case (comp_reg)
                                2'd0:    r_reg <= cq;
                                2'd1:    g_reg <= cq;
                                default: b_reg <= cq;
                            endcase
                        if (mode_reg == MODE_BLACK || comp_reg == 2'd2 ||
                            mode_reg == MODE_GRAY)
                            state_reg <= ST_EMIT;
                        else
                        begin
                            // red-blue skips green
                            comp_reg  <= (mode_reg == MODE_RB) ? 2'd2 : comp_reg + 2'd1;
                            state_reg <= ST_COL;
                        end
                    end
                // hold the finished result until the output register is free
                ST_EMIT:
                    if (slot_free)
                    begin
                        odata_reg <= '{q_reg, r_reg, g_reg, b_reg, empty_reg};
                        state_reg <= ST_IDLE;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a finished result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result dropped under stall");
    // the fill count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CountW'(MaxPoints))
        else $error("sample count overflow");
    // the walk stays inside the filled part of the store
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> idx_reg < count_reg)
        else $error("read past fill count");
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for inverse_distance_color_map
// Drives clear, load, query and unused beats through the input channel. A
// predictor inside the bench keeps its own sample store and extent, and it
// predicts each query (Shepard weighting plus color) as the beat is accepted.
// A checker compares every output beat, field by field, with the oldest
// prediction. Both channel sides idle at random. The color mode is changed
// only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import idcm_pkg::*;

    localparam int GapMax     = 15;
    localparam int SettleCyc  = 40;      // quiet time after the last result
    localparam int RandItems  = 1700;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    idcm_in_if  in_ch ();
    idcm_out_if out_ch ();

    inverse_distance_color_map DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the store, the extent and the mode.
    // ------------------------------------------------------------------------
    logic signed [15:0] pt_x   [MaxPoints];
    logic signed [15:0] pt_y   [MaxPoints];
    logic signed [15:0] pt_val [MaxPoints];
    int                 pt_count;
    logic signed [15:0] val_min;
    logic signed [15:0] val_max;
    logic [1:0]         color_mode;

    out_item_t          pending_q[$];    // predicted query beats, oldest first
    int                 fail_count;
    int                 beats_checked;
    int                 beats_sent;
    int                 queries_sent;

    // Sender and receiver pacing controls.
    bit                 tx_idle;
    bit                 rx_idle;
    int                 rx_hold;         // long receiver hold-off, in cycles

    // Truncated color of value v between val_min and val_max.
    function automatic void color_of(input logic signed [15:0] v,
                                     output logic [7:0] r,
                                     output logic [7:0] g,
                                     output logic [7:0] b);
        longint span;
        longint n;
        longint an;
        span = longint'(val_max) - longint'(val_min);
        r = '0;
        g = '0;
        b = '0;
        // flat range: use the mid value
        if (span <= 0)
        begin
            span = 1;
            n    = 0;
        end
        else
        begin
            n = 2 * (longint'(v) - longint'(val_min)) - span;
            if (n > span)
                n = span;
            if (n < -span)
                n = -span;
        end
        an = (n < 0) ? -n : n;
        case (color_mode)
            MODE_RB:
            begin
                r = 8'(127 * (span - n) / span);
                b = 8'(127 * (span + n) / span);
            end
            MODE_RGB:
            begin
                r = (n < 0) ? 8'(255 * an / span) : 8'd0;
                g = 8'(255 * (span - an) / span);
                b = (n > 0) ? 8'(255 * an / span) : 8'd0;
            end
            MODE_GRAY:
            begin
                r = 8'(127 * (span + n) / span);
                g = r;
                b = r;
            end
            default: ;
        endcase
    endfunction

    // Weighted mean at (qx, qy); a query exactly on a sample takes its value.
    function automatic out_item_t shepard_result(input logic signed [15:0] qx,
                                                 input logic signed [15:0] qy);
        out_item_t          res;
        longint unsigned    num;
        longint unsigned    den;
        longint unsigned    d2;
        longint unsigned    w;
        longint             dx;
        longint             dy;
        logic signed [15:0] mean;
        bit                 hit;
        res  = '0;
        num  = 0;
        den  = 0;
        hit  = 1'b0;
        mean = '0;
        if (pt_count == 0)
        begin
            res.store_empty = 1'b1;
            return res;
        end
        for (int i = 0; i < pt_count; i++)
        begin
            if (!hit)
            begin
                dx = longint'(qx) - longint'(pt_x[i]);
                dy = longint'(qy) - longint'(pt_y[i]);
                d2 = longint'(dx * dx + dy * dy);
                if (d2 == 0)
                begin
                    hit  = 1'b1;
                    mean = pt_val[i];
                end
                else
                begin
                    w   = (64'd1 << WeightShift) / d2;
                    num += w * longint'(longint'(pt_val[i]) + 32768);
                    den += w;
                end
            end
        end
        if (!hit)
            mean = 16'(longint'(num / den) - 32768);
        res.interp_value = mean;
        color_of(mean, res.red, res.green, res.blue);
        return res;
    endfunction

    // Advance the predictor by one accepted input beat.
    task automatic track_beat(input in_item_t it);
        case (kind_t'(it.kind))
            KIND_CLEAR:
            begin
                pt_count = 0;
                val_min  = '0;
                val_max  = '0;
            end
            KIND_LOAD:
            begin
                // drop loads once the store is full
                if (pt_count < MaxPoints)
                begin
                    pt_x[pt_count]   = it.pos_x;
                    pt_y[pt_count]   = it.pos_y;
                    pt_val[pt_count] = it.sample_value;
                    if (pt_count == 0)
                    begin
                        val_min = it.sample_value;
                        val_max = it.sample_value;
                    end
                    else
                    begin
                        if (it.sample_value < val_min)
                            val_min = it.sample_value;
                        if (it.sample_value > val_max)
                            val_max = it.sample_value;
                    end
                    pt_count++;
                end
            end
            KIND_QUERY:
            begin
                pending_q.push_back(shepard_result(it.pos_x, it.pos_y));
                queries_sent++;
            end
            default: ;   // unused kind: no effect, no result
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Sender: one beat per call. Each call starts at a rising edge.
    // ------------------------------------------------------------------------
    task automatic send_beat(input in_item_t it);
        int gap;
        gap = tx_idle ? $urandom_range(0, GapMax) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        track_beat(it);
        beats_sent++;
    endtask

    function automatic in_item_t make_item(input kind_t k,
                                           input logic [15:0] x,
                                           input logic [15:0] y,
                                           input logic [15:0] v);
        in_item_t it;
        it.kind         = k;
        it.pos_x        = x;
        it.pos_y        = y;
        it.sample_value = v;
        return it;
    endfunction

    // Hold the sender until every predicted beat has come, then settle.
    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SettleCyc) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        color_mode = m;
    endtask

    // ------------------------------------------------------------------------
    // Receiver pacing: a random stall before each beat, plus rare long holds.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = rx_idle ? $urandom_range(0, GapMax) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // Checker: compare every output beat with the oldest prediction.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result beat %p", $time, out_ch.data);
                fail_count++;
            end
            else
            begin
                want = pending_q.pop_front();
                beats_checked++;
                if (out_ch.data.interp_value !== want.interp_value)
                begin
                    $display("%0t: interp_value expected %0d actual %0d", $time,
                             want.interp_value, out_ch.data.interp_value);
                    fail_count++;
                end
                if (out_ch.data.red !== want.red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time,
                             want.red, out_ch.data.red);
                    fail_count++;
                end
                if (out_ch.data.green !== want.green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time,
                             want.green, out_ch.data.green);
                    fail_count++;
                end
                if (out_ch.data.blue !== want.blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time,
                             want.blue, out_ch.data.blue);
                    fail_count++;
                end
                if (out_ch.data.store_empty !== want.store_empty)
                begin
                    $display("%0t: store_empty expected %0d actual %0d", $time,
                             want.store_empty, out_ch.data.store_empty);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty store, unused kind, clear, flat range, exact hit and extremes.
    task automatic test_directed;
        write_mode(MODE_GRAY);
        send_beat(make_item(KIND_QUERY, 16'h0000, 16'h0000, 16'h0000));
        send_beat(make_item(KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(make_item(KIND_CLEAR, 16'h8000, 16'h7FFF, 16'h1234));
        // single point: flat range
        send_beat(make_item(KIND_LOAD, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_beat(make_item(KIND_QUERY, 16'h7FFF, 16'h8000, 16'h0000));
        send_beat(make_item(KIND_QUERY, 16'h8000, 16'h7FFF, 16'h0000));
        send_beat(make_item(KIND_LOAD, 16'h8000, 16'h7FFF, 16'h8000));
        // query on the second sample, then the far corners
        send_beat(make_item(KIND_QUERY, 16'h8000, 16'h7FFF, 16'hFFFF));
        send_beat(make_item(KIND_QUERY, 16'h8000, 16'h8000, 16'h0000));
        send_beat(make_item(KIND_QUERY, 16'h7FFF, 16'h7FFF, 16'h0000));
        send_beat(make_item(KIND_LOAD, 16'h0000, 16'h0000, 16'h0000));
        send_beat(make_item(KIND_QUERY, 16'h0001, 16'h0000, 16'h0000));
        // duplicate position: the first stored point wins
        send_beat(make_item(KIND_LOAD, 16'h0000, 16'h0000, 16'h0100));
        send_beat(make_item(KIND_QUERY, 16'h0000, 16'h0000, 16'h0000));
        write_mode(MODE_RB);
        send_beat(make_item(KIND_QUERY, 16'h0400, 16'hFC00, 16'h0000));
        send_beat(make_item(KIND_QUERY, 16'h8000, 16'h7FFF, 16'h0000));
        write_mode(MODE_RGB);
        send_beat(make_item(KIND_QUERY, 16'h7FFF, 16'h8000, 16'h0000));
        send_beat(make_item(KIND_QUERY, 16'h8000, 16'h7FFF, 16'h0000));
        send_beat(make_item(KIND_QUERY, 16'h1000, 16'h1000, 16'h0000));
        write_mode(MODE_BLACK);
        send_beat(make_item(KIND_QUERY, 16'h1000, 16'h1000, 16'h0000));
        send_beat(make_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000));
        send_beat(make_item(KIND_QUERY, 16'h1000, 16'h1000, 16'h0000));
        drain();
    endtask

    // Fill past capacity; dropped loads must not move the extent.
    task automatic test_store_full;
        write_mode(MODE_RGB);
        send_beat(make_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000));
        for (int i = 0; i < MaxPoints; i++)
            send_beat(make_item(KIND_LOAD, 16'($urandom), 16'($urandom),
                                16'($urandom_range(0, 2000) - 1000)));
        send_beat(make_item(KIND_LOAD, 16'h0000, 16'h0000, 16'h7FFF));
        send_beat(make_item(KIND_LOAD, 16'h0001, 16'h0001, 16'h8000));
        send_beat(make_item(KIND_QUERY, 16'h0000, 16'h0000, 16'h0000));
        send_beat(make_item(KIND_QUERY, pt_x[MaxPoints-1], pt_y[MaxPoints-1], 16'h0));
        send_beat(make_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000));
        drain();
    endtask

    // Hold the receiver off for a long stretch while queries keep coming.
    task automatic test_backpressure;
        write_mode(MODE_RB);
        send_beat(make_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000));
        send_beat(make_item(KIND_LOAD, 16'h1000, 16'h0000, 16'h0200));
        send_beat(make_item(KIND_LOAD, 16'h0000, 16'h1000, 16'hFE00));
        rx_hold = 3000;
        tx_idle = 1'b0;
        for (int i = 0; i < 12; i++)
            send_beat(make_item(KIND_QUERY, 16'($urandom), 16'($urandom), 16'h0));
        tx_idle = 1'b1;
        drain();
    endtask

    // Random phases: a small store, then queries near, on and away from it.
    task automatic test_random;
        int                 npts;
        int                 nq;
        int                 pick;
        int                 j;
        logic signed [15:0] base;
        logic [15:0]        qx;
        logic [15:0]        qy;
        while (beats_sent < RandItems)
        begin
            if ($urandom_range(0, 3) == 0)
                write_mode(2'($urandom));
            // stretches with no idling on either side
            tx_idle = ($urandom_range(0, 4) != 0);
            rx_idle = ($urandom_range(0, 4) != 0);
            send_beat(make_item(KIND_CLEAR, 16'($urandom), 16'($urandom),
                                16'($urandom)));
            npts = $urandom_range(0, 6);
            base = 16'($urandom);
            for (int i = 0; i < npts; i++)
            begin
                pick = $urandom_range(0, 3);
                send_beat(make_item(KIND_LOAD, 16'($urandom), 16'($urandom),
                                    (pick == 0) ? base : 16'($urandom)));
            end
            nq = $urandom_range(1, 8);
            for (int i = 0; i < nq; i++)
            begin
                pick = $urandom_range(0, 9);
                qx   = 16'($urandom);
                qy   = 16'($urandom);
                if (pt_count > 0 && pick < 6)
                begin
                    j  = $urandom_range(0, pt_count - 1);
                    qx = pt_x[j];
                    qy = pt_y[j];
                    if (pick >= 2)
                    begin
                        qx = qx + 16'($urandom_range(0, 64) - 32);
                        qy = qy + 16'($urandom_range(0, 64) - 32);
                    end
                end
                if (pick == 9)
                    send_beat(make_item(KIND_NONE, qx, qy, 16'($urandom)));
                else if (pick == 8 && pt_count < 8)
                    send_beat(make_item(KIND_LOAD, qx, qy, 16'($urandom)));
                else
                    send_beat(make_item(KIND_QUERY, qx, qy, 16'($urandom)));
            end
            // pause until everything is back now and then
            if ($urandom_range(0, 7) == 0)
                drain();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = MODE_BLACK;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        pt_count      = 0;
        val_min       = '0;
        val_max       = '0;
        color_mode    = MODE_BLACK;
        fail_count    = 0;
        beats_checked = 0;
        beats_sent    = 0;
        queries_sent  = 0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        rx_hold       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_store_full();
        test_backpressure();
        test_random();
        repeat (200) @(posedge clk);

        $display("Covered %0d input beats and %0d query results over all color modes,",
                 beats_sent, beats_checked);
        $display("with clears, full store, exact hits and random stalls on both sides.");
        if (fail_count == 0 && pending_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog: a generous fixed limit on the whole run.
    initial
    begin
        #50_000_000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
